@@ sv/scp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    // command codes
    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // denial codes
    localparam logic [2:0] DEN_NONE     = 3'd0;
    localparam logic [2:0] DEN_NOT_INIT = 3'd1;
    localparam logic [2:0] DEN_INVALID  = 3'd2;
    localparam logic [2:0] DEN_CONFLICT = 3'd3;
    localparam logic [2:0] DEN_NO_RED   = 3'd4;

    // output layout
    localparam logic [4:0] A_RED = 5'd0;
    localparam logic [4:0] A_GRN = 5'd2;
    localparam logic [4:0] B_RED = 5'd3;
    localparam logic [4:0] B_GRN = 5'd5;
    localparam logic [4:0] C_RED = 5'd6;
    localparam logic [4:0] C_GRN = 5'd8;
    localparam logic [4:0] D_RED = 5'd9;
    localparam logic [4:0] D_GRN = 5'd11;
    localparam logic [4:0] P_RED = 5'd12;
    localparam logic [4:0] P_GRN = 5'd13;

    localparam logic [31:0] VEH_GREENS = (32'd1 << A_GRN) | (32'd1 << B_GRN)
                                       | (32'd1 << C_GRN) | (32'd1 << D_GRN);
    localparam logic [31:0] ALL_GREENS = VEH_GREENS | (32'd1 << P_GRN);

    typedef logic [31:0] t_word;

    // verdict on one requested bit
    typedef struct packed {
        logic       fail;
        logic [2:0] denial;
        logic [4:0] culprit;
    } t_verdict;

    // outputs that conflict with output idx
    function automatic t_word conflicts_of(input logic [4:0] idx);
        t_word res;
        res = '0;
        case (idx)
            A_GRN, B_GRN, C_GRN, D_GRN: res = ALL_GREENS & ~(32'd1 << idx);
            P_GRN:                      res = VEH_GREENS;
            default:                    res = '0;
        endcase
        return res;
    endfunction

    // the red that must precede a green; has_red low for non-greens
    function automatic logic [5:0] red_for(input logic [4:0] idx);
        logic [5:0] res;
        res = '0;
        case (idx)
            A_GRN:   res = {1'b1, A_RED};
            B_GRN:   res = {1'b1, B_RED};
            C_GRN:   res = {1'b1, C_RED};
            D_GRN:   res = {1'b1, D_RED};
            P_GRN:   res = {1'b1, P_RED};
            default: res = '0;
        endcase
        return res;
    endfunction

    // lowest set green position; collisions only ever land on greens
    function automatic logic [4:0] lowest_green(input t_word coll);
        logic [4:0] res;
        res = P_GRN;
        if (coll[A_GRN]) begin
            res = A_GRN;
        end else if (coll[B_GRN]) begin
            res = B_GRN;
        end else if (coll[C_GRN]) begin
            res = C_GRN;
        end else if (coll[D_GRN]) begin
            res = D_GRN;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/scp_bit_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module scp_bit_check
    import scp_pkg::*;
#(
    parameter int NUM_OUTPUTS = 20
) (
    input  wire logic [4:0]             i_idx,
    input  wire logic [NUM_OUTPUTS-1:0] i_active,
    input  wire logic [NUM_OUTPUTS-1:0] i_previous,
    output t_verdict                    o_verdict
);

    t_word      active_w;
    t_word      prev_w;
    t_word      coll;
    logic [5:0] red;

    assign active_w = {{(32-NUM_OUTPUTS){1'b0}}, i_active};
    assign prev_w   = {{(32-NUM_OUTPUTS){1'b0}}, i_previous};
    assign coll     = active_w & conflicts_of(i_idx);
    assign red      = red_for(i_idx);

    // checks in priority order: range, conflict, prior red
    always_comb begin
        o_verdict = '{fail: 1'b0, denial: DEN_NONE, culprit: i_idx};
        if (32'(i_idx) >= 32'(NUM_OUTPUTS)) begin
            o_verdict.fail   = 1'b1;
            o_verdict.denial = DEN_INVALID;
        end else if (coll != '0) begin
            o_verdict.fail    = 1'b1;
            o_verdict.denial  = DEN_CONFLICT;
            o_verdict.culprit = lowest_green(coll);
        end else if (red[5] && !prev_w[red[4:0]]) begin
            o_verdict.fail   = 1'b1;
            o_verdict.denial = DEN_NO_RED;
        end
    end

endmodule

`default_nettype wire

@@ sv/signal_conflict_permissive_check_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Signal conflict monitor. Each beat carries a command: check a request mask,
// update the active outputs, or clear both masks and arm the monitor. Update,
// clear and unused commands present their result in the cycle after acceptance.
// A check walks the request bits from bit 0 upward through one shared bit
// checker, one bit per cycle, and stops at the first failing bit or once no
// higher request bit remains. A check before the first clear returns a
// not-initialised denial at once. No new beat is taken until the result beat
// has been taken downstream.
module signal_conflict_permissive_check_unit
    import scp_pkg::*;
#(
    parameter int NUM_OUTPUTS = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_cmd,
    input  wire logic [31:0]            i_mask,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_granted,
    output logic [2:0]                  o_denial,
    output logic [4:0]                  o_culprit_output,
    output logic [NUM_OUTPUTS-1:0]      o_active_now
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [4:0] NONE_IDX = 5'(NUM_OUTPUTS);

    logic [1:0]             r_state,   n_state;
    logic [31:0]            r_mask,    n_mask;
    logic [4:0]             r_idx,     n_idx;
    logic                   r_granted, n_granted;
    logic [2:0]             r_denial,  n_denial;
    logic [4:0]             r_culprit, n_culprit;
    logic [NUM_OUTPUTS-1:0] r_active,  n_active;
    logic [NUM_OUTPUTS-1:0] r_prev,    n_prev;
    logic                   r_ready,   n_ready;

    logic     in_acc;
    t_verdict verdict;

    assign in_acc = i_in_valid && !o_in_stall;

    // shared per-bit checker
    scp_bit_check #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_bit_check (
        .i_idx      (r_idx),
        .i_active   (r_active),
        .i_previous (r_prev),
        .o_verdict  (verdict)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_mask    = r_mask;
        n_idx     = r_idx;
        n_granted = r_granted;
        n_denial  = r_denial;
        n_culprit = r_culprit;
        n_active  = r_active;
        n_prev    = r_prev;
        n_ready   = r_ready;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_granted = 1'b0;
                    n_denial  = DEN_NONE;
                    n_culprit = NONE_IDX;
                    n_state   = S_DONE;
                    case (i_cmd)
                        CMD_CHECK: begin
                            if (!r_ready) begin
                                n_denial = DEN_NOT_INIT;
                            end else begin
                                n_mask  = i_mask;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_UPDATE: begin
                            n_prev   = r_active;
                            n_active = i_mask[NUM_OUTPUTS-1:0];
                        end
                        CMD_CLEAR: begin
                            n_prev   = '0;
                            n_active = '0;
                            n_ready  = 1'b1;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // test the bit at the bottom of the shifted request
                if (r_mask[0] && verdict.fail) begin
                    n_denial  = verdict.denial;
                    n_culprit = verdict.culprit;
                    n_state   = S_DONE;
                end else if (r_mask[31:1] == '0) begin
                    n_granted = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_mask = {1'b0, r_mask[31:1]};
                    n_idx  = r_idx + 5'd1;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_prev   <= '0;
            r_ready  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_prev   <= n_prev;
            r_ready  <= n_ready;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mask    <= n_mask;
        r_idx     <= n_idx;
        r_granted <= n_granted;
        r_denial  <= n_denial;
        r_culprit <= n_culprit;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = (r_state == S_DONE);
    assign o_granted        = r_granted;
    assign o_denial         = r_denial;
    assign o_culprit_output = r_culprit;
    assign o_active_now     = r_active;

`ifndef NO_ASSERTIONS
    a_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_denial == DEN_NONE && o_culprit_output == NONE_IDX)
        else $error("grant beat carries a denial");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result beat is pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("no busy cycle after an accepted beat");

    a_not_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_ready |-> !o_granted)
        else $error("grant before initialisation");
`endif

endmodule

`default_nettype wire
